/* design/x10fb_pkg.sv */
// Shared types, constants and the frame builder for the X10 frame bit buffer.
package x10fb_pkg;

   localparam int FRAME_BITS = 22;
   localparam int BIT_IDX_W = 5;
   localparam logic [3:0] START_CODE = 4'b1110;

   typedef enum logic [1:0] {
      OP_APPEND_ADDR = 2'd0,
      OP_APPEND_CMD  = 2'd1,
      OP_CONSUME     = 2'd2,
      OP_CLEAR       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_FETCH = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       append;
      logic       suffix;
      logic       fetch;
      logic       advance;
      logic       clear;
      logic       load;
      logic       use_mem;
      status_type status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic rsp_busy;
   } stat_type;

   // each bit followed by its inverse, MSB first
   function automatic logic [7:0] comp_nibble(input logic [3:0] v);
      logic [7:0] r;
      for (int i = 0; i < 4; i++) begin
         r[2*i+1] = v[i];
         r[2*i]   = ~v[i];
      end
      return r;
   endfunction

   // first bit sent sits in the MSB
   function automatic logic [FRAME_BITS-1:0] frame_word(input logic [3:0] house,
                                                        input logic [3:0] code,
                                                        input logic       suffix);
      return {START_CODE, comp_nibble(house), comp_nibble(code), suffix, ~suffix};
   endfunction

endpackage

/* design/x10fb_ctrl.sv */
// Request sequencer for the X10 frame bit buffer.
module x10fb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_operation,
   output logic               req_stall,
   input  logic               rsp_stall,
   input  x10fb_pkg::stat_type stat,
   output x10fb_pkg::cmd_type  cmd
);

   x10fb_pkg::state_type state_ff, state_in;
   x10fb_pkg::op_type    op;
   logic                 take;

   assign op        = x10fb_pkg::op_type'(req_operation);
   assign req_stall = !((state_ff == x10fb_pkg::S_IDLE) && (!stat.rsp_busy || !rsp_stall));
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= x10fb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         x10fb_pkg::S_IDLE: begin
            if (take && op == x10fb_pkg::OP_CONSUME && !stat.empty) begin
               state_in = x10fb_pkg::S_FETCH;
            end
         end
         x10fb_pkg::S_FETCH: begin
            state_in = x10fb_pkg::S_IDLE;
         end
         default: state_in = x10fb_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status = x10fb_pkg::ST_OK;
      case (state_ff)
         x10fb_pkg::S_IDLE: begin
            if (take) begin
               case (op)
                  x10fb_pkg::OP_APPEND_ADDR, x10fb_pkg::OP_APPEND_CMD: begin
                     cmd.load = 1'b1;
                     if (stat.full) begin
                        cmd.status = x10fb_pkg::ST_FULL;
                     end else begin
                        cmd.append = 1'b1;
                        cmd.suffix = (op == x10fb_pkg::OP_APPEND_CMD);
                     end
                  end
                  x10fb_pkg::OP_CONSUME: begin
                     if (stat.empty) begin
                        cmd.load   = 1'b1;
                        cmd.status = x10fb_pkg::ST_EMPTY;
                     end else begin
                        cmd.fetch = 1'b1;
                     end
                  end
                  x10fb_pkg::OP_CLEAR: begin
                     cmd.load  = 1'b1;
                     cmd.clear = 1'b1;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         x10fb_pkg::S_FETCH: begin
            cmd.load    = 1'b1;
            cmd.use_mem = 1'b1;
            cmd.advance = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* design/x10fb_datapath.sv */
// Frame memory, read/write pointers and response register of the X10 frame bit buffer.
module x10fb_datapath #(
   parameter int CAPACITY_BITS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [3:0]         req_house,
   input  logic [3:0]         req_code,
   input  x10fb_pkg::cmd_type  cmd,
   output x10fb_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_bit_res,
   output logic [1:0]         rsp_status
);

   localparam int FRAMES  = CAPACITY_BITS / x10fb_pkg::FRAME_BITS;
   localparam int CNT_W   = $clog2(FRAMES + 1);
   localparam int FIDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam logic [CNT_W-1:0] FRAMES_C = CNT_W'(FRAMES);
   localparam logic [x10fb_pkg::BIT_IDX_W-1:0] LAST_BIT =
      x10fb_pkg::BIT_IDX_W'(x10fb_pkg::FRAME_BITS - 1);

   // frames always start at multiples of the frame length, so store whole frames
   logic [x10fb_pkg::FRAME_BITS-1:0] frame_mem [FRAMES];
   logic [x10fb_pkg::FRAME_BITS-1:0] mem_rd_ff;

   logic [CNT_W-1:0]                  wr_frame_ff, rd_frame_ff;
   logic [x10fb_pkg::BIT_IDX_W-1:0]   rd_bit_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_bit_ff;
   x10fb_pkg::status_type             rsp_status_ff;
   logic [x10fb_pkg::BIT_IDX_W-1:0]   bit_sel;

   assign stat.full     = (wr_frame_ff == FRAMES_C);
   assign stat.empty    = (rd_frame_ff == wr_frame_ff);
   assign stat.rsp_busy = rsp_valid_ff;

   assign bit_sel = LAST_BIT - rd_bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         frame_mem[wr_frame_ff[FIDX_W-1:0]] <= x10fb_pkg::frame_word(req_house, req_code,
                                                                     cmd.suffix);
      end
      if (cmd.fetch) begin
         mem_rd_ff <= frame_mem[rd_frame_ff[FIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_frame_ff <= '0;
         rd_frame_ff <= '0;
         rd_bit_ff   <= '0;
      end else if (cmd.clear) begin
         wr_frame_ff <= '0;
         rd_frame_ff <= '0;
         rd_bit_ff   <= '0;
      end else begin
         if (cmd.append) begin
            wr_frame_ff <= wr_frame_ff + CNT_W'(1);
         end
         if (cmd.advance) begin
            if (rd_bit_ff == LAST_BIT) begin
               rd_bit_ff   <= '0;
               rd_frame_ff <= rd_frame_ff + CNT_W'(1);
            end else begin
               rd_bit_ff <= rd_bit_ff + x10fb_pkg::BIT_IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_bit_ff    <= cmd.use_mem ? mem_rd_ff[bit_sel] : 1'b0;
         rsp_status_ff <= cmd.status;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bit_res = rsp_bit_ff;
   assign rsp_status  = rsp_status_ff;

   a_rd_not_past_wr: assert property (@(posedge clock) disable iff (reset)
      rd_frame_ff <= wr_frame_ff)
      else $error("read pointer passed write pointer");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_frame_ff <= FRAMES_C)
      else $error("write pointer beyond capacity");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while stalled");

   a_fetch_then_load: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> (cmd.load && cmd.use_mem))
      else $error("fetched bit not delivered");

   a_drained_reads_zero_offset: assert property (@(posedge clock) disable iff (reset)
      stat.empty |-> (rd_bit_ff == '0))
      else $error("bit offset set with no frame pending");

endmodule

/* design/x10_frame_bit_buffer.sv */
// Top level of the X10 frame bit buffer: sequencer plus frame datapath.
//
// Request channel (req_valid/req_stall): req_operation selects append address
// frame, append command frame, consume one bit, or clear. req_house and
// req_code feed the two appends. Response channel (rsp_valid/rsp_stall): one
// response per request, carrying rsp_bit_res and rsp_status (ok, nothing left,
// frame rejected as full).
// An append writes a whole 22-bit frame into one entry of the frame memory,
// so appends, clears and refused consumes answer directly: the response is
// valid the cycle after the request is taken. A consume that returns a bit
// first reads its frame into the registered read port of the frame memory
// and then loads the response; the next request is taken once it is loaded.
// Capacity is CAPACITY_BITS / 22 frames; leftover bits are never used.
// Reset empties the buffer at once (no clearing pass) and drops any pending
// response. While rsp_stall holds a waiting response, req_stall is raised and
// no further request is taken.
module x10_frame_bit_buffer #(
   parameter int CAPACITY_BITS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [3:0] req_house,
   input  logic [3:0] req_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_bit_res,
   output logic [1:0] rsp_status
);

   x10fb_pkg::cmd_type  cmd;
   x10fb_pkg::stat_type stat;

   x10fb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_stall     (rsp_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   x10fb_datapath #(
      .CAPACITY_BITS (CAPACITY_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_house   (req_house),
      .req_code    (req_code),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_bit_res (rsp_bit_res),
      .rsp_status  (rsp_status)
   );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the X10 frame bit buffer: random and directed requests.
module testbench;

   localparam int CAPACITY_BITS = 256;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct {
      x10fb_pkg::op_type op;
      logic [3:0]        house;
      logic [3:0]        code;
   } buffer_req_type;

   typedef struct {
      logic                  data_bit;
      x10fb_pkg::status_type status;
   } buffer_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_operation = x10fb_pkg::OP_CLEAR;
   logic [3:0] req_house = 4'd0;
   logic [3:0] req_code = 4'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_bit_res;
   logic [1:0] rsp_status;

   buffer_req_type request_q[$];
   buffer_rsp_type pending_responses[$];

   // predicted buffer contents
   logic frame_store [CAPACITY_BITS];
   int   write_total = 0;
   int   read_total = 0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count = 0;
   int cycle_count = 0;

   x10_frame_bit_buffer #(.CAPACITY_BITS(CAPACITY_BITS)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_house     (req_house),
      .req_code      (req_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bit_res   (rsp_bit_res),
      .rsp_status    (rsp_status)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic buffer_rsp_type buffer_step(x10fb_pkg::op_type op,
                                                  logic [3:0] house,
                                                  logic [3:0] code);
      buffer_rsp_type r;
      logic [x10fb_pkg::FRAME_BITS-1:0] frame;
      logic sfx;
      r.data_bit = 1'b0;
      r.status   = x10fb_pkg::ST_OK;
      case (op)
         x10fb_pkg::OP_APPEND_ADDR, x10fb_pkg::OP_APPEND_CMD: begin
            if (write_total + x10fb_pkg::FRAME_BITS > CAPACITY_BITS) begin
               r.status = x10fb_pkg::ST_FULL;
            end else begin
               sfx = (op == x10fb_pkg::OP_APPEND_CMD);
               frame = {x10fb_pkg::START_CODE,
                        house[3], ~house[3], house[2], ~house[2],
                        house[1], ~house[1], house[0], ~house[0],
                        code[3], ~code[3], code[2], ~code[2],
                        code[1], ~code[1], code[0], ~code[0],
                        sfx, ~sfx};
               for (int i = 0; i < x10fb_pkg::FRAME_BITS; i++)
                  frame_store[write_total + i] = frame[x10fb_pkg::FRAME_BITS - 1 - i];
               write_total += x10fb_pkg::FRAME_BITS;
            end
         end
         x10fb_pkg::OP_CONSUME: begin
            if (read_total < write_total) begin
               r.data_bit = frame_store[read_total];
               read_total++;
            end else begin
               r.status = x10fb_pkg::ST_EMPTY;
            end
         end
         default: begin
            write_total = 0;
            read_total  = 0;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic push_request(input x10fb_pkg::op_type op, input logic [3:0] house,
                               input logic [3:0] code);
      buffer_req_type r;
      r.op    = op;
      r.house = house;
      r.code  = code;
      request_q.push_back(r);
   endtask

   // mostly clear / append frames / read them back, with some random noise
   task automatic gen_random(input int n);
      int added;
      int frames;
      int reads;
      added = 0;
      while (added < n) begin
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(5, 15)) begin
               push_request(x10fb_pkg::op_type'($urandom_range(0, 3)), 4'($urandom),
                            4'($urandom));
               added++;
            end
         end else begin
            push_request(x10fb_pkg::OP_CLEAR, 4'($urandom), 4'($urandom));
            frames = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 13)
                                                : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
               push_request($urandom_range(0, 1) ? x10fb_pkg::OP_APPEND_CMD
                                                 : x10fb_pkg::OP_APPEND_ADDR,
                            4'($urandom), 4'($urandom));
            reads = (frames > 3) ? $urandom_range(20, 60)
                                 : $urandom_range(frames * 22 - 5, frames * 22 + 3);
            for (int k = 0; k < reads; k++) begin
               // occasional append in the middle of a drain
               if ($urandom_range(0, 99) < 3) begin
                  push_request(x10fb_pkg::OP_APPEND_ADDR, 4'($urandom), 4'($urandom));
                  added++;
               end
               push_request(x10fb_pkg::OP_CONSUME, 4'($urandom), 4'($urandom));
            end
            added += 1 + frames + reads;
         end
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      gen_random(n);
      while (request_q.size() > 0 || req_valid) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      logic           take;
      buffer_req_type nxt;
      take = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (take)
            pending_responses.push_back(buffer_step(x10fb_pkg::op_type'(req_operation),
                                                    req_house, req_code));
         if (!req_valid || take) begin
            if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = request_q.pop_front();
               req_valid     <= 1'b1;
               req_operation <= nxt.op;
               req_house     <= nxt.house;
               req_code      <= nxt.code;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      buffer_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = pending_responses.pop_front();
               if (rsp_bit_res !== want.data_bit)
                  report_mismatch($sformatf("bit_res %b, expected %b",
                                            rsp_bit_res, want.data_bit));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: drained buffer, extreme codes, both frame kinds, full buffer
      push_request(x10fb_pkg::OP_CONSUME, 4'hF, 4'hF);
      push_request(x10fb_pkg::OP_APPEND_ADDR, 4'h0, 4'hF);
      push_request(x10fb_pkg::OP_APPEND_CMD, 4'hF, 4'h0);
      repeat (5) push_request(x10fb_pkg::OP_CONSUME, 4'h0, 4'h0);
      push_request(x10fb_pkg::OP_CLEAR, 4'hA, 4'h5);
      push_request(x10fb_pkg::OP_CONSUME, 4'h5, 4'hA);
      for (int i = 0; i < 12; i++)
         push_request(i[0] ? x10fb_pkg::OP_APPEND_CMD : x10fb_pkg::OP_APPEND_ADDR,
                      i[0] ? 4'hA : 4'h5, i[0] ? 4'h5 : 4'hA);
      push_request(x10fb_pkg::OP_CONSUME, 4'h0, 4'h0);
      push_request(x10fb_pkg::OP_CLEAR, 4'h0, 4'h0);

      run_phase(0, 0, 170);
      run_phase(68, 0, 165);
      run_phase(0, 68, 165);
      run_phase(23, 23, 165);

      while (pending_responses.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
design/x10fb_pkg.sv
design/x10fb_ctrl.sv
design/x10fb_datapath.sv
design/x10_frame_bit_buffer.sv
tb/sv/testbench.sv
